### src/bcc_pkg.sv
`timescale 1ns / 1ps
// Package of the multi-button click classifier: register codes, reset values,
// field widths and the event word type. It depends on nothing else.
package bcc_pkg;

	localparam int CHANNELS_DEF   = 4;
	localparam int COUNT_BITS_DEF = 12;

	localparam int LEVEL_BITS  = 4;
	localparam int SERVED_BITS = 2;
	localparam int CCOUNT_BITS = 3;
	localparam int THRESH_BITS = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 12;
	localparam int TALLY_BITS  = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_WINDOW  = 2'd3;

	localparam logic [CCOUNT_BITS-1:0] CHANNEL_COUNT_RST = 3'd1;
	localparam logic [THRESH_BITS-1:0] DEBOUNCE_RST      = 12'd60;
	localparam logic [THRESH_BITS-1:0] LONG_PRESS_RST    = 12'd1000;
	localparam logic [THRESH_BITS-1:0] CLICK_WINDOW_RST  = 12'd600;

	localparam logic [TALLY_BITS-1:0] TALLY_NONE   = 2'd0;
	localparam logic [TALLY_BITS-1:0] TALLY_ONE    = 2'd1;
	localparam logic [TALLY_BITS-1:0] TALLY_TWO    = 2'd2;
	localparam logic [TALLY_BITS-1:0] TALLY_THREE  = 2'd3;

	typedef struct packed {
		logic press;
		logic release_ev;
		logic short_ev;
		logic long_ev;
		logic single_ev;
		logic double_ev;
	} evt_t;

	typedef struct packed {
		logic [THRESH_BITS-1:0] debounce;
		logic [THRESH_BITS-1:0] hold;
		logic [THRESH_BITS-1:0] click_window;
	} thresh_t;

endpackage

### src/multi_button_click_classifier.sv
`timescale 1ns / 1ps
// Multi-button click classifier: round-robin debounce, press and click detection.
// An accepted word is registered in stage 1 and then in the output register.
// Throughput: one word per cycle unless the output stalls; per-channel state sits
// in one RAM read on acceptance, with forwarding when consecutive words serve the same channel.
// Reset clears control and per-entry valid bits and loads configuration reset values; no clearing pass.
// Depends on bcc_pkg, bcc_ram and bcc_update.
module multi_button_click_classifier #(
	parameter int CHANNELS   = bcc_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = bcc_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bcc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bcc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bcc_pkg::LEVEL_BITS-1:0]      button_levels,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bcc_pkg::SERVED_BITS-1:0]     served_channel,
	output logic                                press_event,
	output logic                                release_event,
	output logic                                short_press_event,
	output logic                                long_press_event,
	output logic                                single_click_event,
	output logic                                double_click_event
);
	import bcc_pkg::*;

	localparam int PW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNTW = $clog2(CHANNELS + 1);
	localparam int CMPW = (CNTW > CCOUNT_BITS) ? CNTW : CCOUNT_BITS;
	localparam int SW   = 3 * COUNT_BITS + 7;
	// Skip flag is set after reset; every other field starts at zero.
	localparam logic [SW-1:0] STATE_RST = SW'(1) << (COUNT_BITS + TALLY_BITS + 2);

	logic [CCOUNT_BITS-1:0] ccount_q;
	thresh_t                thr_q;
	logic [PW-1:0]          ptr_q;
	logic [CHANNELS-1:0]    vld_q;

	logic                   s1_valid_s1;
	logic [PW-1:0]          ch_s1;
	logic                   high_s1;
	logic                   rd_vld_s1;
	logic                   fwd_hit_s1;
	logic [SW-1:0]          fwd_data_s1;

	logic                   out_valid_q;
	logic [SERVED_BITS-1:0] served_q;
	evt_t                   evt_q;

	logic                   accept;
	logic                   out_free;
	logic                   s1_adv;
	logic [CMPW-1:0]        eff_cnt;
	logic [CMPW-1:0]        ptr_inc;
	logic [PW-1:0]          ch_next;
	logic                   high_next;
	logic [SW-1:0]          rdata;
	logic [SW-1:0]          cur_state;
	logic [SW-1:0]          new_state;
	evt_t                   evt;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid_s1 && out_free;
	assign in_stall  = s1_valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		eff_cnt = CMPW'(ccount_q);
		if (eff_cnt == '0) begin
			eff_cnt = CMPW'(1);
		end
		if (eff_cnt > CMPW'(CHANNELS)) begin
			eff_cnt = CMPW'(CHANNELS);
		end
		ptr_inc = CMPW'(ptr_q) + 1'b1;
		ch_next = (ptr_inc >= eff_cnt) ? '0 : PW'(ptr_inc);
		high_next = 1'b1;
		for (int i = 0; i < LEVEL_BITS; i++) begin
			if (CMPW'(ch_next) == CMPW'(i)) begin
				high_next = button_levels[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccount_q           <= CHANNEL_COUNT_RST;
			thr_q.debounce     <= DEBOUNCE_RST;
			thr_q.hold         <= LONG_PRESS_RST;
			thr_q.click_window <= CLICK_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: ccount_q           <= CCOUNT_BITS'(cfg_data);
				REG_DEBOUNCE:      thr_q.debounce     <= cfg_data;
				REG_LONG_PRESS:    thr_q.hold         <= cfg_data;
				REG_CLICK_WINDOW:  thr_q.click_window <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			vld_q       <= '0;
			s1_valid_s1 <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				vld_q[ch_s1] <= 1'b1;
			end
			if (accept) begin
				ptr_q       <= ch_next;
				s1_valid_s1 <= 1'b1;
				fwd_hit_s1  <= s1_adv && (ch_s1 == ch_next);
				rd_vld_s1   <= vld_q[ch_next];
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1       <= ch_next;
			high_s1     <= high_next;
			fwd_data_s1 <= new_state;
		end
		if (s1_adv) begin
			served_q <= SERVED_BITS'(ch_s1);
			evt_q    <= evt;
		end
	end

	bcc_ram #(
		.WIDTH(SW),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (ch_s1),
		.wdata (new_state),
		.re    (accept),
		.raddr (ch_next),
		.rdata (rdata)
	);

	always_comb begin
		if (fwd_hit_s1) begin
			cur_state = fwd_data_s1;
		end else if (rd_vld_s1) begin
			cur_state = rdata;
		end else begin
			cur_state = STATE_RST;
		end
	end

	bcc_update #(
		.COUNT_BITS(COUNT_BITS),
		.SW(SW)
	) u_update (
		.high      (high_s1),
		.state_in  (cur_state),
		.thresh    (thr_q),
		.state_out (new_state),
		.events    (evt)
	);

	assign out_valid          = out_valid_q;
	assign served_channel     = served_q;
	assign press_event        = evt_q.press;
	assign release_event      = evt_q.release_ev;
	assign short_press_event  = evt_q.short_ev;
	assign long_press_event   = evt_q.long_ev;
	assign single_click_event = evt_q.single_ev;
	assign double_click_event = evt_q.double_ev;

endmodule

### src/bcc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module bcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/bcc_update.sv
`timescale 1ns / 1ps
// Per-channel update of the debounce, press and click-window state for one tick.
// It depends on bcc_pkg.
module bcc_update #(
	parameter int COUNT_BITS = bcc_pkg::COUNT_BITS_DEF,
	parameter int SW = 3 * COUNT_BITS + 7
) (
	input  logic                    high,
	input  logic [SW-1:0]           state_in,
	input  bcc_pkg::thresh_t        thresh,
	output logic [SW-1:0]           state_out,
	output bcc_pkg::evt_t           events
);
	import bcc_pkg::*;

	localparam int TW = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;

	typedef struct packed {
		logic                  rel_lock;
		logic                  prs_lock;
		logic [COUNT_BITS-1:0] high_cnt;
		logic [COUNT_BITS-1:0] low_cnt;
		logic                  skip;
		logic                  pend;
		logic [TALLY_BITS-1:0] tally;
		logic                  win_act;
		logic [COUNT_BITS-1:0] win_cnt;
	} chst_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic hits(input logic [COUNT_BITS-1:0] c,
		input logic [THRESH_BITS-1:0] t);
		return TW'(c) == TW'(t);
	endfunction

	chst_t s;
	evt_t  e;

	always_comb begin
		s = chst_t'(state_in);
		e = '0;
		if (high) begin
			s.prs_lock = 1'b0;
			s.low_cnt  = '0;
			if (!s.rel_lock) begin
				s.high_cnt = sat_inc(s.high_cnt);
				if (hits(s.high_cnt, thresh.debounce)) begin
					s.rel_lock = 1'b1;
					if (s.skip) begin
						s.skip = 1'b0;
					end else begin
						e.release_ev = 1'b1;
					end
				end
			end
			if (s.pend) begin
				s.pend = 1'b0;
				e.short_ev = 1'b1;
			end
		end else begin
			s.rel_lock = 1'b0;
			s.high_cnt = '0;
			if (!s.prs_lock) begin
				s.low_cnt = sat_inc(s.low_cnt);
				if (hits(s.low_cnt, thresh.debounce)) begin
					if (s.skip) begin
						s.skip = 1'b0;
					end else begin
						s.pend  = 1'b1;
						e.press = 1'b1;
						s.tally = s.tally + 1'b1;
						if (s.tally == TALLY_THREE) begin
							s.tally = TALLY_ONE;
						end
						if (!s.win_act) begin
							s.win_act = 1'b1;
							s.win_cnt = '0;
						end
					end
				end else if (hits(s.low_cnt, thresh.hold)) begin
					s.prs_lock = 1'b1;
					if (s.pend) begin
						s.pend = 1'b0;
						e.long_ev = 1'b1;
					end
				end
			end
		end
		if (s.win_act) begin
			s.win_cnt = sat_inc(s.win_cnt);
			if (hits(s.win_cnt, thresh.click_window)) begin
				s.win_act = 1'b0;
				if (s.tally == TALLY_ONE) begin
					e.single_ev = 1'b1;
				end
				s.tally = TALLY_NONE;
			end else if (s.tally == TALLY_TWO) begin
				s.win_act = 1'b0;
				e.double_ev = 1'b1;
			end
		end
	end

	assign state_out = SW'(s);
	assign events    = e;

endmodule
